### src/rbd_pkg.sv
`default_nettype none

package rbd_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 7;
  // result word: data, status, count, padded to whole bytes
  localparam int unsigned RES_W   = WORD_W + STAT_W + COUNT_W;
  localparam int unsigned M_DATA_W = ((RES_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

`default_nettype wire

### src/rbd_ram.sv
`default_nettype none

module rbd_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             addr,
  input  wire logic [rbd_pkg::WORD_W-1:0] wdata,
  output logic      [rbd_pkg::WORD_W-1:0] rdata
);
  import rbd_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

### src/ring_buffer_deque.sv
// channel | dir | tdata                                  | tuser
// s       | in  | value[31:0]                            | cmd[1:0]
// m       | out | data[31:0] status[33:32] count[40:34]  | -
//
// one operation per cycle sustained while the output is not stalled; a result
// passes the read stage (RAM read at the accepting edge), then the output register.
// the rate is set by the single RAM port, used at most once per operation. reset
// clears indices, count and valid flags; the RAM is not cleared. while the output
// stalls, only an empty read stage takes a word, parks it there, then drops s_tready.
`default_nettype none

module ring_buffer_deque #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // slave side
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [rbd_pkg::WORD_W-1:0]   s_tdata,  // value[31:0]
  input  wire logic [rbd_pkg::CMD_W-1:0]    s_tuser,  // cmd[1:0]
  // master side
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic      [rbd_pkg::M_DATA_W-1:0] m_tdata   // data[31:0] status[33:32] count[40:34]
);
  import rbd_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // index and count registers
  logic [IW-1:0] front, front_next;
  logic [IW-1:0] back, back_next;
  logic [CW-1:0] occ, occ_next;

  // read stage
  logic          p1_valid;
  logic          p1_pop;
  status_t       p1_status;
  logic [CW-1:0] p1_count;

  // output register
  logic              out_valid;
  logic [WORD_W-1:0] out_data;
  status_t           out_status;
  logic [COUNT_W-1:0] out_count;

  // ram
  logic              ram_en, ram_we;
  logic [IW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_rdata;

  cmd_t          cmd;
  status_t       st;
  logic          pop_ok;
  logic          full, empty;
  logic          accept, p1_move;
  logic [IW-1:0] front_up, front_dn, back_up, back_dn;
  logic [CW+COUNT_W-1:0] count_ext;

  assign cmd   = cmd_t'(s_tuser);
  assign full  = (occ == CW'(DEPTH));
  assign empty = (occ == '0);

  // wrapping index steps
  assign front_up = (front == IW'(DEPTH - 1)) ? '0 : front + 1'b1;
  assign front_dn = (front == '0) ? IW'(DEPTH - 1) : front - 1'b1;
  assign back_up  = (back == IW'(DEPTH - 1)) ? '0 : back + 1'b1;
  assign back_dn  = (back == '0) ? IW'(DEPTH - 1) : back - 1'b1;

  // handshake
  assign p1_move  = !out_valid || m_tready;
  assign s_tready = !p1_valid || p1_move;
  assign accept   = s_tvalid && s_tready;

  // operation decode
  always_comb begin
    front_next = front;
    back_next  = back;
    occ_next   = occ;
    st         = ST_OK;
    pop_ok     = 1'b0;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = front;
    unique case (cmd)
      CMD_PUSH_FRONT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          front_next = front_dn;
          ram_addr   = front_dn;
          ram_en     = accept;
          ram_we     = 1'b1;
          occ_next   = occ + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          back_next = back_up;
          ram_addr  = back;
          ram_en    = accept;
          ram_we    = 1'b1;
          occ_next  = occ + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          front_next = front_up;
          ram_addr   = front;
          ram_en     = accept;
          pop_ok     = 1'b1;
          occ_next   = occ - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          back_next = back_dn;
          ram_addr  = back_dn;
          ram_en    = accept;
          pop_ok    = 1'b1;
          occ_next  = occ - 1'b1;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  rbd_ram #(
    .DEPTH (DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (s_tdata),
    .rdata (ram_rdata)
  );

  // indices and count
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
      occ   <= '0;
    end else if (accept) begin
      front <= front_next;
      back  <= back_next;
      occ   <= occ_next;
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (s_tready) begin
      p1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_pop    <= pop_ok;
      p1_status <= st;
      p1_count  <= occ_next;
    end
  end

  // output register
  assign count_ext = {{COUNT_W{1'b0}}, p1_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p1_move) begin
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move && p1_valid) begin
      out_data   <= p1_pop ? ram_rdata : '0;
      out_status <= p1_status;
      out_count  <= count_ext[COUNT_W-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_DATA_W - RES_W){1'b0}}, out_count, out_status, out_data};

`ifndef NO_ASSERTIONS
  // a rejected operation returns a word with zero data
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_status != ST_OK)) |-> (out_data == '0))
    else $error("rejected operation returned nonzero data");

  // count stays within capacity
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(DEPTH))
    else $error("occupancy above capacity");

  // an accepted push into a non-full queue grows it by one
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tuser[1] && !full) |=> (occ == $past(occ) + 1'b1))
    else $error("push did not grow occupancy");

  // input is held off only behind a stalled output
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");
`endif

endmodule

`default_nettype wire

### sim/tb_ring_buffer_deque.sv
`timescale 1ns / 1ps

module tb_ring_buffer_deque;
  import rbd_pkg::*;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned RANDOM_OPS = 1750;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned TAIL_WAIT  = 10;

  // one expected result word
  typedef struct packed {
    logic [WORD_W-1:0]  data;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } reply_t;

  // kinds of random run segments
  typedef enum int {
    SEG_FILL,
    SEG_DRAIN,
    SEG_PUSHY,
    SEG_POPPY,
    SEG_MIXED
  } seg_kind_t;

  // shadow deque plus the queue of replies still owed by the block
  class deque_scoreboard;
    logic [WORD_W-1:0] slots [DEPTH];
    logic [IDX_W-1:0]  head;
    logic [IDX_W-1:0]  tail;
    int unsigned       held;
    reply_t            replies [$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       full_rejects;
    int unsigned       empty_rejects;
    int unsigned       peak;

    function new();
      head          = '0;
      tail          = '0;
      held          = 0;
      errors        = 0;
      checked       = 0;
      full_rejects  = 0;
      empty_rejects = 0;
      peak          = 0;
    endfunction

    // apply one accepted operation to the shadow deque
    function void note_op(cmd_t op, logic [WORD_W-1:0] word);
      reply_t r;
      r.data   = '0;
      r.status = ST_OK;
      if (op == CMD_PUSH_FRONT || op == CMD_PUSH_BACK) begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
          full_rejects++;
        end else if (op == CMD_PUSH_FRONT) begin
          // front steps down, wrapping from 0 to the top slot
          head = head - 1'b1;
          slots[head] = word;
          held++;
        end else begin
          slots[tail] = word;
          tail = tail + 1'b1;
          held++;
        end
      end else begin
        if (held == 0) begin
          r.status = ST_EMPTY;
          empty_rejects++;
        end else if (op == CMD_POP_FRONT) begin
          r.data = slots[head];
          head = head + 1'b1;
          held--;
        end else begin
          // back points one past the last word
          tail = tail - 1'b1;
          r.data = slots[tail];
          held--;
        end
      end
      if (held > peak) peak = held;
      r.count = COUNT_W'(held);
      replies.push_back(r);
    endfunction

    // compare one result word against the oldest owed reply
    function void check_reply(logic [M_DATA_W-1:0] beat);
      reply_t             want;
      logic [WORD_W-1:0]  got_data;
      logic [STAT_W-1:0]  got_status;
      logic [COUNT_W-1:0] got_count;
      got_data   = beat[WORD_W-1:0];
      got_status = beat[WORD_W+STAT_W-1:WORD_W];
      got_count  = beat[RES_W-1:WORD_W+STAT_W];
      if (replies.size() == 0) begin
        $error("result word with nothing expected: data %h status %0d count %0d",
               got_data, got_status, got_count);
        errors++;
        return;
      end
      want = replies.pop_front();
      checked++;
      if (got_data !== want.data) begin
        $error("data mismatch: expected %h, actual %h", want.data, got_data);
        errors++;
      end
      if (got_status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got_status);
        errors++;
      end
      if (got_count !== want.count) begin
        $error("count mismatch: expected %0d, actual %0d", want.count, got_count);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return replies.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [WORD_W-1:0]   s_tdata;   // value[31:0]
  logic [CMD_W-1:0]    s_tuser;   // cmd[1:0]
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;   // data[31:0] status[33:32] count[40:34]

  deque_scoreboard sb = new();
  int unsigned     ops_sent;
  int unsigned     burst_left;
  bit              gaps_on;
  int unsigned     quiet_cycles;

  ring_buffer_deque #(
    .DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_reply(m_tdata);
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver stall pattern: always ready, coin flip, periodic, or mostly stalled
  initial begin
    int unsigned mode;
    int unsigned len;
    int unsigned period;
    int unsigned open;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      mode   = $urandom_range(0, 3);
      len    = $urandom_range(20, 200);
      period = $urandom_range(2, 12);
      open   = $urandom_range(1, period - 1);
      for (int unsigned i = 0; i < len; i++) begin
        @(negedge clk);
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (i % period) < open;
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // drive one operation and wait for it to be taken
  task automatic send_op(cmd_t op, logic [WORD_W-1:0] word);
    if (gaps_on && burst_left == 0) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 30);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    sb.note_op(op, word);
    ops_sent++;
  endtask

  // hold the sender off until every owed reply has come back
  task automatic wait_for_replies();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic cmd_t pick_op(int unsigned push_pct);
    bit at_front;
    at_front = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < push_pct) return at_front ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    return at_front ? CMD_POP_FRONT : CMD_POP_BACK;
  endfunction

  initial begin
    seg_kind_t   kind;
    int unsigned push_pct;
    int unsigned seg_len;
    int unsigned random_sent;
    int unsigned seg_no;
    int unsigned tail_cycles;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = CMD_PUSH_FRONT;
    quiet_cycles = 0;
    ops_sent     = 0;
    burst_left   = 0;
    gaps_on      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty pops, wrap of both indices, extreme words, both ends
    send_op(CMD_POP_FRONT, 32'h1234_5678);
    send_op(CMD_POP_BACK, '1);
    send_op(CMD_PUSH_FRONT, 32'h7fff_ffff);
    send_op(CMD_POP_BACK, '0);
    send_op(CMD_PUSH_BACK, 32'h8000_0000);
    send_op(CMD_PUSH_FRONT, 32'hffff_ffff);
    send_op(CMD_PUSH_BACK, 32'h0000_0000);
    send_op(CMD_POP_FRONT, '0);
    send_op(CMD_POP_FRONT, '0);
    send_op(CMD_POP_BACK, '0);
    send_op(CMD_POP_BACK, '0);
    send_op(CMD_PUSH_BACK, 32'h5555_5555);
    send_op(CMD_PUSH_FRONT, 32'haaaa_aaaa);
    send_op(CMD_POP_FRONT, 32'h5555_5555);
    send_op(CMD_POP_BACK, 32'haaaa_aaaa);
    wait_for_replies();

    // random segments; the first two fill past full and drain past empty
    random_sent = 0;
    seg_no      = 0;
    while (random_sent < RANDOM_OPS) begin
      case (seg_no)
        0: kind = SEG_FILL;
        1: kind = SEG_DRAIN;
        default: kind = seg_kind_t'($urandom_range(0, 4));
      endcase
      case (kind)
        SEG_FILL:  push_pct = 100;
        SEG_DRAIN: push_pct = 0;
        SEG_PUSHY: push_pct = 75;
        SEG_POPPY: push_pct = 25;
        default:   push_pct = 50;
      endcase
      seg_len = (kind == SEG_FILL || kind == SEG_DRAIN) ? $urandom_range(70, 90)
                                                        : $urandom_range(20, 120);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int unsigned i = 0; i < seg_len && random_sent < RANDOM_OPS; i++) begin
        send_op(pick_op(push_pct), pick_word());
        random_sent++;
      end
      if ($urandom_range(0, 5) == 0) wait_for_replies();
      seg_no++;
    end

    // drain the pipeline
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    tail_cycles = 0;
    while (tail_cycles < TAIL_WAIT) begin
      @(posedge clk);
      tail_cycles++;
    end

    $display("%0d operations in %0d random segments, %0d results checked",
             ops_sent, seg_no, sb.checked);
    $display("%0d pushes refused when full, %0d pops refused when empty, peak fill %0d of %0d",
             sb.full_rejects, sb.empty_rejects, sb.peak, DEPTH);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
src/rbd_pkg.sv
src/rbd_ram.sv
src/ring_buffer_deque.sv
sim/tb_ring_buffer_deque.sv
